/* sv/assert_macros.svh */
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* sv/lds_pkg.sv */
// Package with constants, types and structs of the LOOK disk scheduler.
package lds_pkg;

	localparam int MaxRequests = 32;
	localparam int AddrW = $clog2(MaxRequests);
	localparam int CountW = $clog2(MaxRequests + 1);
	localparam int CylW = 16;
	localparam int TotalW = 17;
	localparam int KeyW = CylW + AddrW;

	typedef logic [CylW-1:0] cyl_t;
	typedef logic [TotalW-1:0] total_t;
	typedef logic [KeyW-1:0] key_t;
	typedef logic [CountW-1:0] count_t;
	typedef logic [AddrW-1:0] addr_t;

	localparam cyl_t TopReset = cyl_t'(199);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} state_t;

	typedef enum logic {
		REG_HEAD = 1'b0,
		REG_TOP  = 1'b1
	} cfg_reg_t;

	// Control from the sequencer to the candidate picker.
	typedef struct packed {
		logic clear;
		logic vld;
		key_t key;
		logic desc;
		cyl_t head;
		logic have_last;
		key_t last_key;
	} pick_ctl_t;

	// Outcome of one scan.
	typedef struct packed {
		logic found;
		key_t key;
	} pick_res_t;

endpackage

/* sv/lds_pick.sv */
// Candidate picker: keeps the best next request seen during one scan of the store.
module lds_pick (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lds_pkg::pick_ctl_t   ctl,
	output lds_pkg::pick_res_t   res
);
	import lds_pkg::*;

	logic found_q;
	key_t best_q;
	cyl_t value;
	logic in_group;
	logic past_last;
	logic better;
	logic take;

	// Keys are {cylinder, store index}, so equal cylinders still order strictly.
	always_comb begin
		value = ctl.key[KeyW-1:AddrW];
		in_group = ctl.desc ? (value < ctl.head) : (value >= ctl.head);
		past_last = !ctl.have_last ||
			(ctl.desc ? (ctl.key < ctl.last_key) : (ctl.key > ctl.last_key));
		better = !found_q || (ctl.desc ? (ctl.key > best_q) : (ctl.key < best_q));
		take = ctl.vld && in_group && past_last && better;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q <= ctl.key;
		end
	end

	assign res.found = found_q;
	assign res.key = best_q;

endmodule

/* sv/look_disk_scheduler_top.sv */
// Top level of the LOOK disk scheduler: request store, sequencer and result registers.
// Loading takes one request item per cycle with busy low; the item marked last schedules.
// Each result then takes one scan of the store through the scan, drain and decide states,
// plus one extra scan when the sweep turns.
// Results come on a one-cycle strobe; the receiver cannot stall them.
// Reset clears count, overflow flag, sequencer and registers (head 0, top 199), not the store.
module look_disk_scheduler_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  lds_pkg::cyl_t       cfg_data,
	input  logic                start,
	output logic                busy,
	input  lds_pkg::cyl_t       request_cylinder,
	input  logic                last_request,
	output logic                result_valid,
	output lds_pkg::cyl_t       from_cylinder,
	output lds_pkg::cyl_t       to_cylinder,
	output lds_pkg::cyl_t       move_distance,
	output lds_pkg::total_t     total_seek,
	output logic                last_move,
	output logic                request_overflow
);
	import lds_pkg::*;

	// Configuration registers, written whenever the write enable is high.
	cyl_t head_q;
	cyl_t top_q;

	// The request store. Only entries below the count are ever used by a scan.
	cyl_t mem [MaxRequests];

	// Batch bookkeeping.
	count_t count_q;
	logic   ovf_q;
	cyl_t   bhead_q;      // head position sampled with the last item
	logic   upper_first_q;

	// Sequencer.
	state_t state_q;
	state_t state_d;
	count_t rd_addr_q;
	count_t emit_cnt_q;
	logic   phase_q;      // 0 while the first sweep runs, 1 after the turn
	logic   have_last_q;
	key_t   last_key_q;
	cyl_t   pos_q;
	total_t total_q;

	// Registered read port of the store.
	cyl_t   rd_data_s1;
	addr_t  rd_idx_s1;
	logic   rd_vld_s1;

	// Result registers.
	logic   strobe_q;
	cyl_t   from_q;
	cyl_t   to_q;
	cyl_t   dist_q;
	total_t total_out_q;
	logic   last_move_q;
	logic   ovf_out_q;

	pick_ctl_t pick_ctl;
	pick_res_t pick_res;

	logic   accept;
	logic   store_full;
	logic   upper_first_d;
	cyl_t   head_gap;
	cyl_t   best_val;
	cyl_t   dist_d;
	logic   batch_done;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign store_full = (count_q >= count_t'(MaxRequests));

	// The upper group goes first when the head is at least as far from cylinder 0
	// as from the top cylinder.
	always_comb begin
		head_gap = (head_q >= top_q) ? (head_q - top_q) : (top_q - head_q);
		upper_first_d = (head_q >= head_gap);
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			top_q <= TopReset;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_HEAD: head_q <= cfg_data;
				REG_TOP:  top_q <= cfg_data;
				default:  head_q <= head_q;
			endcase
		end
	end

	// Store write while loading, registered read while scanning.
	always_ff @(posedge clk) begin
		if (accept && !store_full) begin
			mem[count_q[AddrW-1:0]] <= request_cylinder;
		end
		rd_data_s1 <= mem[rd_addr_q[AddrW-1:0]];
		rd_idx_s1 <= rd_addr_q[AddrW-1:0];
	end

	// The picker walks the current sweep direction: descending for the lower group.
	always_comb begin
		pick_ctl.clear = (state_q == ST_SCAN) && (rd_addr_q == '0);
		pick_ctl.vld = rd_vld_s1;
		pick_ctl.key = {rd_data_s1, rd_idx_s1};
		pick_ctl.desc = (phase_q == upper_first_q);
		pick_ctl.head = bhead_q;
		pick_ctl.have_last = have_last_q;
		pick_ctl.last_key = last_key_q;
	end

	lds_pick u_pick (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pick_ctl),
		.res    (pick_res)
	);

	// Move arithmetic for the chosen request.
	always_comb begin
		best_val = pick_res.key[KeyW-1:AddrW];
		dist_d = (best_val >= pos_q) ? (best_val - pos_q) : (pos_q - best_val);
		batch_done = (emit_cnt_q + count_t'(1) == count_q);
	end

	// Next state. A scan issues n reads, drains the last read, then decides.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && last_request) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rd_addr_q + count_t'(1) == count_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (pick_res.found && batch_done) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer datapath and batch bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q <= 1'b0;
			rd_addr_q <= '0;
			rd_vld_s1 <= 1'b0;
			emit_cnt_q <= '0;
			phase_q <= 1'b0;
			have_last_q <= 1'b0;
			upper_first_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					rd_addr_q <= '0;
					if (accept) begin
						if (store_full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + count_t'(1);
						end
						if (last_request) begin
							emit_cnt_q <= '0;
							phase_q <= 1'b0;
							have_last_q <= 1'b0;
							upper_first_q <= upper_first_d;
						end
					end
				end
				ST_SCAN: begin
					rd_addr_q <= rd_addr_q + count_t'(1);
				end
				ST_DRAIN: begin
					rd_addr_q <= '0;
				end
				ST_DECIDE: begin
					rd_addr_q <= '0;
					if (pick_res.found) begin
						strobe_q <= 1'b1;
						have_last_q <= 1'b1;
						emit_cnt_q <= emit_cnt_q + count_t'(1);
						if (batch_done) begin
							count_q <= '0;
							ovf_q <= 1'b0;
						end
					end else begin
						// First sweep exhausted: turn and rescan from the far end.
						phase_q <= 1'b1;
						have_last_q <= 1'b0;
					end
				end
				default: rd_addr_q <= '0;
			endcase
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (accept && last_request) begin
			bhead_q <= head_q;
			pos_q <= head_q;
			total_q <= '0;
		end else if (state_q == ST_DECIDE && pick_res.found) begin
			last_key_q <= pick_res.key;
			pos_q <= best_val;
			total_q <= total_q + total_t'(dist_d);
			from_q <= pos_q;
			to_q <= best_val;
			dist_q <= dist_d;
			total_out_q <= total_q + total_t'(dist_d);
			last_move_q <= batch_done;
			ovf_out_q <= ovf_q;
		end
	end

	assign result_valid = strobe_q;
	assign from_cylinder = from_q;
	assign to_cylinder = to_q;
	assign move_distance = dist_q;
	assign total_seek = total_out_q;
	assign last_move = last_move_q;
	assign request_overflow = ovf_out_q;

	`include "assert_macros.svh"

	// A decision that found a request always produces exactly one result strobe.
	`ASSERT_NEXT(a_found_strobes, clk, arst_n, (state_q == ST_DECIDE) && pick_res.found, strobe_q)
	// The final move of a batch leaves the block ready for the next batch.
	`ASSERT_IMP(a_last_idle, clk, arst_n, strobe_q && last_move_q, state_q == ST_IDLE)
	// The stored count never exceeds the store depth.
	`ASSERT_IMP(a_count_cap, clk, arst_n, 1'b1, count_q <= count_t'(MaxRequests))
	// An accepted last item always starts scheduling.
	`ASSERT_NEXT(a_last_starts, clk, arst_n, accept && last_request, busy)
	// While scheduling, the store holds at least one request.
	`ASSERT_IMP(a_busy_nonempty, clk, arst_n, busy, count_q != '0)

endmodule

/* sim/look_disk_scheduler_top_test.sv */
// Self-checking testbench for the LOOK disk scheduler top level.
`timescale 1ns / 1ps

module look_disk_scheduler_top_test;
	import lds_pkg::*;

	// Run shape. The block is already idle when the last move of a batch comes out;
	// SettleCycles is only a quiet margin before a register write or the end.
	localparam int ResetCycles = 11;
	localparam int ItemTarget = 300;
	localparam int QuietFrom = 240;
	localparam int SettleCycles = 2 * (MaxRequests + 2) + 8;
	localparam int WatchdogLimit = 2000;
	localparam int NumRows = 31;

	// One head move as it appears on the result ports.
	typedef struct packed {
		cyl_t   from_cyl;
		cyl_t   to_cyl;
		cyl_t   move_len;
		total_t total;
		logic   last;
		logic   overflow;
	} move_t;

	typedef enum logic {
		ROW_WRITE,
		ROW_REQUEST
	} row_kind_t;

	// A directed row either writes one register or sends one request item. Rows with
	// typed set carry the single move they must produce, written out by hand.
	typedef struct packed {
		row_kind_t kind;
		cfg_reg_t  reg_sel;
		cyl_t      value;
		logic      last;
		logic      typed;
		move_t     want;
	} stim_row_t;

	localparam move_t NoMove = '0;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   cfg_we = 1'b0;
	logic   cfg_index = REG_HEAD;
	cyl_t   cfg_data = '0;
	logic   start = 1'b0;
	logic   busy;
	cyl_t   request_cylinder = '0;
	logic   last_request = 1'b0;
	logic   result_valid;
	cyl_t   from_cylinder;
	cyl_t   to_cylinder;
	cyl_t   move_distance;
	total_t total_seek;
	logic   last_move;
	logic   request_overflow;

	// Our own copy of the scheduler state: stored requests, drop flag and registers.
	cyl_t stored_cyl [MaxRequests];
	int   stored_count = 0;
	bit   dropped_any = 1'b0;
	cyl_t head_reg = '0;
	cyl_t top_reg = TopReset;

	// Moves predicted but not yet seen on the result ports, oldest first.
	move_t pending_moves [$];
	int    mismatches = 0;
	int    items_sent = 0;
	int    quiet_cycles = 0;

	// Directed part. The first rows run on reset values (head 0, top 199), where a lone
	// request gives a move that can be read off directly. Later rows cover a head in the
	// middle with requests on both sides and on the head itself, repeated cylinders,
	// the out-of-range top cylinder of zero, and the extreme head and top values.
	stim_row_t directed_rows [NumRows] = '{
		'{ROW_REQUEST, REG_HEAD, 16'd0,     1'b1, 1'b1,
			'{16'd0, 16'd0, 16'd0, 17'd0, 1'b1, 1'b0}},
		'{ROW_REQUEST, REG_HEAD, 16'd65535, 1'b1, 1'b1,
			'{16'd0, 16'd65535, 16'd65535, 17'd65535, 1'b1, 1'b0}},
		'{ROW_REQUEST, REG_HEAD, 16'd199,   1'b1, 1'b1,
			'{16'd0, 16'd199, 16'd199, 17'd199, 1'b1, 1'b0}},
		'{ROW_WRITE,   REG_HEAD, 16'd100,   1'b0, 1'b0, NoMove},
		'{ROW_REQUEST, REG_HEAD, 16'd150,   1'b0, 1'b0, NoMove},
		'{ROW_REQUEST, REG_HEAD, 16'd50,    1'b0, 1'b0, NoMove},
		'{ROW_REQUEST, REG_HEAD, 16'd100,   1'b0, 1'b0, NoMove},
		'{ROW_REQUEST, REG_HEAD, 16'd100,   1'b0, 1'b0, NoMove},
		'{ROW_REQUEST, REG_HEAD, 16'd30,    1'b0, 1'b0, NoMove},
		'{ROW_REQUEST, REG_HEAD, 16'd199,   1'b1, 1'b0, NoMove},
		'{ROW_WRITE,   REG_HEAD, 16'd40,    1'b0, 1'b0, NoMove},
		'{ROW_REQUEST, REG_HEAD, 16'd10,    1'b0, 1'b0, NoMove},
		'{ROW_REQUEST, REG_HEAD, 16'd60,    1'b0, 1'b0, NoMove},
		'{ROW_REQUEST, REG_HEAD, 16'd0,     1'b0, 1'b0, NoMove},
		'{ROW_REQUEST, REG_HEAD, 16'd65535, 1'b1, 1'b0, NoMove},
		'{ROW_WRITE,   REG_TOP,  16'd0,     1'b0, 1'b0, NoMove},
		'{ROW_REQUEST, REG_HEAD, 16'd39,    1'b0, 1'b0, NoMove},
		'{ROW_REQUEST, REG_HEAD, 16'd40,    1'b0, 1'b0, NoMove},
		'{ROW_REQUEST, REG_HEAD, 16'd41,    1'b1, 1'b0, NoMove},
		'{ROW_WRITE,   REG_HEAD, 16'd65535, 1'b0, 1'b0, NoMove},
		'{ROW_WRITE,   REG_TOP,  16'd65535, 1'b0, 1'b0, NoMove},
		'{ROW_REQUEST, REG_HEAD, 16'd65535, 1'b1, 1'b1,
			'{16'd65535, 16'd65535, 16'd0, 17'd0, 1'b1, 1'b0}},
		'{ROW_REQUEST, REG_HEAD, 16'd0,     1'b0, 1'b0, NoMove},
		'{ROW_REQUEST, REG_HEAD, 16'd65535, 1'b0, 1'b0, NoMove},
		'{ROW_REQUEST, REG_HEAD, 16'd1,     1'b0, 1'b0, NoMove},
		'{ROW_REQUEST, REG_HEAD, 16'd32768, 1'b1, 1'b0, NoMove},
		'{ROW_WRITE,   REG_HEAD, 16'd0,     1'b0, 1'b0, NoMove},
		'{ROW_WRITE,   REG_TOP,  16'd0,     1'b0, 1'b0, NoMove},
		'{ROW_REQUEST, REG_HEAD, 16'd5,     1'b0, 1'b0, NoMove},
		'{ROW_REQUEST, REG_HEAD, 16'd0,     1'b0, 1'b0, NoMove},
		'{ROW_REQUEST, REG_HEAD, 16'd5,     1'b1, 1'b0, NoMove}
	};

	look_disk_scheduler_top DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.start            (start),
		.busy             (busy),
		.request_cylinder (request_cylinder),
		.last_request     (last_request),
		.result_valid     (result_valid),
		.from_cylinder    (from_cylinder),
		.to_cylinder      (to_cylinder),
		.move_distance    (move_distance),
		.total_seek       (total_seek),
		.last_move        (last_move),
		.request_overflow (request_overflow)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stores one request and, on the item marked last, plans the LOOK sweep over the
	// stored requests and queues one move per request. Returns the number of moves queued.
	// Once the store is full every further request is dropped, a marked one included,
	// but the marked one still closes the batch.
	function automatic int take_request(cyl_t cyl, bit last);
		cyl_t   sorted [MaxRequests];
		cyl_t   order [MaxRequests];
		cyl_t   v;
		int     n, i, j, split, k;
		int     h, t, gap, pos, step_len;
		total_t total;
		bit     upper_first;
		move_t  m;
		if (stored_count < MaxRequests) begin
			stored_cyl[stored_count] = cyl;
			stored_count++;
		end else begin
			dropped_any = 1'b1;
		end
		if (!last)
			return 0;

		n = stored_count;
		for (i = 0; i < n; i++) begin
			v = stored_cyl[i];
			j = i;
			while (j > 0 && sorted[j - 1] > v) begin
				sorted[j] = sorted[j - 1];
				j--;
			end
			sorted[j] = v;
		end

		// Requests from split upward are at or above the head.
		h = int'(head_reg);
		split = 0;
		while (split < n && int'(sorted[split]) < h)
			split++;

		// Sweep up first when the head is no closer to cylinder 0 than to the top.
		t = int'(top_reg);
		gap = (h >= t) ? h - t : t - h;
		upper_first = (h >= gap);
		k = 0;
		if (upper_first) begin
			for (i = split; i < n; i++)
				order[k++] = sorted[i];
			for (i = split; i > 0; i--)
				order[k++] = sorted[i - 1];
		end else begin
			for (i = split; i > 0; i--)
				order[k++] = sorted[i - 1];
			for (i = split; i < n; i++)
				order[k++] = sorted[i];
		end

		pos = h;
		total = '0;
		for (i = 0; i < n; i++) begin
			step_len = (pos >= int'(order[i])) ? pos - int'(order[i]) :
				int'(order[i]) - pos;
			total = total + total_t'(step_len);
			m.from_cyl = cyl_t'(pos);
			m.to_cyl = order[i];
			m.move_len = cyl_t'(step_len);
			m.total = total;
			m.last = (i == n - 1);
			m.overflow = dropped_any;
			pending_moves.push_back(m);
			pos = int'(order[i]);
		end

		stored_count = 0;
		dropped_any = 1'b0;
		return n;
	endfunction

	function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, actual %0d", name, want_v, got_v);
			mismatches++;
		end
	endfunction

	// Holds one request item on the ports until the block takes it. Start stays high
	// afterwards; only an idle burst or a pause lowers it, so back-to-back items never
	// see start dropped and raised in the same step.
	task automatic send_request(cyl_t cyl, bit last, bit typed, move_t want);
		int made;
		start <= 1'b1;
		request_cylinder <= cyl;
		last_request <= last;
		do @(posedge clk); while (busy);
		made = take_request(cyl, last);
		if (typed && made == 1)
			pending_moves[pending_moves.size() - 1] = want;
		items_sent++;
	endtask

	task automatic idle_sender(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_for_moves();
		start <= 1'b0;
		do @(posedge clk); while (pending_moves.size() != 0);
	endtask

	// Brings the block to rest: every move seen, then a quiet margin.
	task automatic quiesce();
		wait_for_moves();
		repeat (SettleCycles) @(posedge clk);
	endtask

	// The trailing edge keeps a second write from touching cfg_we in the same step.
	task automatic write_register(cfg_reg_t sel, cyl_t value);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (sel == REG_HEAD)
			head_reg = value;
		else
			top_reg = value;
		@(posedge clk);
	endtask

	function automatic cyl_t pick_setting();
		case ($urandom_range(0, 3))
			0: return cyl_t'(0);
			1: return cyl_t'(16'hFFFF);
			2: return cyl_t'($urandom_range(0, 255));
			default: return cyl_t'($urandom);
		endcase
	endfunction

	// Result side. Every strobed move is matched against the oldest prediction; the
	// receiver cannot stall, so a move is taken at the edge that ends its strobe cycle.
	always @(posedge clk) begin
		move_t want;
		if (arst_n && result_valid) begin
			if (pending_moves.size() == 0) begin
				$error("move from %0d to %0d with no move expected", from_cylinder,
					to_cylinder);
				mismatches++;
			end else begin
				want = pending_moves.pop_front();
				check_field("from_cylinder", want.from_cyl, from_cylinder);
				check_field("to_cylinder", want.to_cyl, to_cylinder);
				check_field("move_distance", want.move_len, move_distance);
				check_field("total_seek", want.total, total_seek);
				check_field("last_move", want.last, last_move);
				check_field("request_overflow", want.overflow, request_overflow);
			end
		end
	end

	// Watchdog: ends the run when neither an item nor a move has been taken for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$error("no item or move taken for %0d cycles", WatchdogLimit);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int   batch_no;
		int   size, mode, sel, tmp;
		bit   quiet, gappy;
		cyl_t pool [3];
		cyl_t cyl;

		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows. Register writes only happen with the block at rest.
		for (int r = 0; r < NumRows; r++) begin
			if (directed_rows[r].kind == ROW_WRITE) begin
				quiesce();
				write_register(directed_rows[r].reg_sel, directed_rows[r].value);
			end else begin
				send_request(directed_rows[r].value, directed_rows[r].last,
					directed_rows[r].typed, directed_rows[r].want);
			end
		end

		// Random batches. The first two overflow the store: one of 33 items, so the
		// marked item itself is dropped, and one of 40. After that most batches are
		// short, some run up to the store depth, and a few overflow it again.
		batch_no = 0;
		while (items_sent < ItemTarget) begin
			quiet = (items_sent >= QuietFrom);

			if (!quiet && batch_no >= 2 && $urandom_range(0, 3) == 0) begin
				quiesce();
				sel = $urandom_range(1, 3);
				if (sel & 1)
					write_register(REG_HEAD, pick_setting());
				if (sel & 2)
					write_register(REG_TOP, pick_setting());
			end

			if (batch_no == 0)
				size = MaxRequests + 1;
			else if (batch_no == 1)
				size = MaxRequests + 8;
			else begin
				tmp = $urandom_range(0, 99);
				if (tmp < 70)
					size = $urandom_range(1, 8);
				else if (tmp < 92)
					size = $urandom_range(9, MaxRequests);
				else
					size = $urandom_range(MaxRequests + 1, MaxRequests + 8);
			end

			// Value styles: anywhere, close around the head, the edge values, or a small
			// pool so that repeated cylinders are common.
			mode = $urandom_range(0, 3);
			foreach (pool[p])
				pool[p] = cyl_t'($urandom);
			gappy = !quiet && ($urandom_range(0, 2) != 0);

			for (int i = 0; i < size; i++) begin
				case (mode)
					0: cyl = cyl_t'($urandom);
					1: begin
						tmp = int'(head_reg) + int'($urandom_range(0, 40)) - 20;
						if (tmp < 0)
							tmp = 0;
						if (tmp > 65535)
							tmp = 65535;
						cyl = cyl_t'(tmp);
					end
					2: begin
						case ($urandom_range(0, 3))
							0: cyl = cyl_t'(0);
							1: cyl = cyl_t'(16'hFFFF);
							2: cyl = head_reg;
							default: cyl = top_reg;
						endcase
					end
					default: cyl = pool[$urandom_range(0, 2)];
				endcase
				send_request(cyl, i == size - 1, 1'b0, NoMove);
				if (gappy && $urandom_range(0, 3) == 0)
					idle_sender($urandom_range(1, 3));
			end

			// Now and then hold off until the batch has fully come out.
			if (!quiet && $urandom_range(0, 7) == 0)
				wait_for_moves();
			else if (!quiet && $urandom_range(0, 2) == 0)
				idle_sender($urandom_range(1, 3));
			batch_no++;
		end

		quiesce();
		if (mismatches == 0 && pending_moves.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/lds_pkg.sv
sv/lds_pick.sv
sv/look_disk_scheduler_top.sv
sim/look_disk_scheduler_top_test.sv
